>>> rtl/mips_pkg.sv
// shared constants, opcodes and types of the mips32 instruction execute block
package mips_pkg;

  localparam int unsigned DMEM_BYTES = 4096;
  localparam int unsigned DMEM_AW    = $clog2(DMEM_BYTES);

  localparam logic [31:0] START_PC_RESET = 32'h0040_0000;
  localparam logic        OPER_PRELOAD   = 1'b1;
  localparam logic        REG_START_PC   = 1'b0;
  localparam logic [4:0]  REG_ZERO       = 5'd0;
  localparam logic [4:0]  REG_LINK       = 5'd31;

  // primary opcodes
  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_REGIMM  = 6'h01;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_BLEZ    = 6'h06;
  localparam logic [5:0] OP_BGTZ    = 6'h07;
  localparam logic [5:0] OP_ADDI    = 6'h08;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_SLTI    = 6'h0a;
  localparam logic [5:0] OP_SLTIU   = 6'h0b;
  localparam logic [5:0] OP_ANDI    = 6'h0c;
  localparam logic [5:0] OP_ORI     = 6'h0d;
  localparam logic [5:0] OP_XORI    = 6'h0e;
  localparam logic [5:0] OP_LUI     = 6'h0f;
  localparam logic [5:0] OP_LB      = 6'h20;
  localparam logic [5:0] OP_LH      = 6'h21;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_LBU     = 6'h24;
  localparam logic [5:0] OP_LHU     = 6'h25;
  localparam logic [5:0] OP_SB      = 6'h28;
  localparam logic [5:0] OP_SH      = 6'h29;
  localparam logic [5:0] OP_SW      = 6'h2b;

  // special function codes
  localparam logic [5:0] FN_SLL     = 6'h00;
  localparam logic [5:0] FN_SRL     = 6'h02;
  localparam logic [5:0] FN_SRA     = 6'h03;
  localparam logic [5:0] FN_SLLV    = 6'h04;
  localparam logic [5:0] FN_SRLV    = 6'h06;
  localparam logic [5:0] FN_SRAV    = 6'h07;
  localparam logic [5:0] FN_JR      = 6'h08;
  localparam logic [5:0] FN_JALR    = 6'h09;
  localparam logic [5:0] FN_SYSCALL = 6'h0c;
  localparam logic [5:0] FN_MFHI    = 6'h10;
  localparam logic [5:0] FN_MTHI    = 6'h11;
  localparam logic [5:0] FN_MFLO    = 6'h12;
  localparam logic [5:0] FN_MTLO    = 6'h13;
  localparam logic [5:0] FN_MULT    = 6'h18;
  localparam logic [5:0] FN_MULTU   = 6'h19;
  localparam logic [5:0] FN_DIV     = 6'h1a;
  localparam logic [5:0] FN_DIVU    = 6'h1b;
  localparam logic [5:0] FN_ADD     = 6'h20;
  localparam logic [5:0] FN_ADDU    = 6'h21;
  localparam logic [5:0] FN_SUB     = 6'h22;
  localparam logic [5:0] FN_SUBU    = 6'h23;
  localparam logic [5:0] FN_AND     = 6'h24;
  localparam logic [5:0] FN_OR      = 6'h25;
  localparam logic [5:0] FN_XOR     = 6'h26;
  localparam logic [5:0] FN_NOR     = 6'h27;
  localparam logic [5:0] FN_SLT     = 6'h2a;
  localparam logic [5:0] FN_SLTU    = 6'h2b;

  // regimm rt codes
  localparam logic [4:0] RT_BLTZ    = 5'd0;
  localparam logic [4:0] RT_BGEZ    = 5'd1;
  localparam logic [4:0] RT_BLTZAL  = 5'd16;
  localparam logic [4:0] RT_BGEZAL  = 5'd17;

  typedef struct packed {
    logic start;
    logic is_div;
    logic is_signed;
  } md_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] hi;
    logic [31:0] lo;
  } md_rsp_t;

  typedef struct packed {
    logic [31:0] executed_pc;
    logic [31:0] next_pc;
    logic        reg_written;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
    logic        store_done;
    logic [11:0] store_address;
    logic [31:0] store_value;
    logic        halted;
    logic        undefined_instr;
  } out_t;

endpackage

>>> rtl/mips32_instruction_execute.sv
// mips32 integer instruction execute block: sequencer, decode, alu and commit
// alu, branch, jump and hi/lo moves go through exec and fin; loads issue and capture each
// byte read, then format; stores write each byte, then read the word back; preload writes a
// word and reads it back; an execute while halted goes to fin; mult and div wait on the md unit
// one request in flight; next request taken in idle, the cycle after the result is handed over
// reset: pc to 0x00400000, registers, hi, lo and halt cleared; data memory unset
module mips32_instruction_execute import mips_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        operation_i,
  input  logic [31:0] instruction_word_i,
  input  logic [11:0] preload_address_i,
  input  logic [31:0] preload_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] executed_pc_o,
  output logic [31:0] next_pc_o,
  output logic        reg_written_o,
  output logic [4:0]  reg_index_o,
  output logic [31:0] reg_value_o,
  output logic        store_done_o,
  output logic [11:0] store_address_o,
  output logic [31:0] store_value_o,
  output logic        halted_o,
  output logic        undefined_instr_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_EXEC = 4'd1;  // register operands valid, decode
  localparam logic [3:0] S_MD   = 4'd2;  // waiting on mult/div unit
  localparam logic [3:0] S_MWR  = 4'd3;  // write one byte per cycle
  localparam logic [3:0] S_MRA  = 4'd4;  // issue byte read
  localparam logic [3:0] S_MRB  = 4'd5;  // capture byte read
  localparam logic [3:0] S_MEND = 4'd6;  // format load or store result
  localparam logic [3:0] S_FIN  = 4'd7;  // commit and hand result to output register

  logic [3:0]  state_q, state_d;
  logic [31:0] pc_q, hi_q, lo_q, start_pc_q;
  logic        halt_q;
  logic [31:0] iw_q;
  out_t        res_q, out_q;
  logic        out_valid_q;
  logic        rhi_we_q, rlo_we_q;
  logic [31:0] rhi_q, rlo_q;

  // byte sequencer for memory requests
  logic [DMEM_AW-1:0] mbase_q;
  logic [31:0]        mdata_q, mword_q;
  logic [1:0]         mlast_q, mcnt_q, rlast;
  logic               mstore_q;

  logic        in_fire, fin_fire, cfg_wr;
  logic [31:0] rf_a, rf_b;
  logic [7:0]  dm_rdata;
  md_req_t     md_req;
  md_rsp_t     md_rsp;

  // decode fields
  logic [5:0]  op, fn;
  logic [4:0]  rt, rd, sh;
  logic [15:0] imm;
  logic [31:0] se, pc4, btarget, ea;

  // decode results
  logic        ex_wr, ex_undef, ex_halt, ex_hi_we, ex_lo_we, ex_md, ex_load, ex_store;
  logic [4:0]  ex_widx;
  logic [31:0] ex_wv, ex_npc, ld_val;
  logic [1:0]  ex_mlast;
  logic        fin_wr;

  assign in_fire  = in_valid_i && in_ready_o;
  assign fin_fire = (state_q == S_FIN) && (!out_valid_q || out_ready_i);
  assign in_ready_o = (state_q == S_IDLE);

  // config port, start_pc is only a readable copy: reset reloads its default
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_START_PC);
  assign prdata = (paddr[2] == REG_START_PC) ? start_pc_q : '0;

  assign op  = iw_q[31:26];
  assign fn  = iw_q[5:0];
  assign rt  = iw_q[20:16];
  assign rd  = iw_q[15:11];
  assign sh  = iw_q[10:6];
  assign imm = iw_q[15:0];
  assign se  = {{16{imm[15]}}, imm};
  assign pc4 = pc_q + 32'd4;
  assign btarget = pc4 + {se[29:0], 2'b00};
  assign ea  = rf_a + se;

  always_comb begin
    ex_wr    = 1'b0;
    ex_widx  = REG_ZERO;
    ex_wv    = '0;
    ex_npc   = pc4;
    ex_undef = 1'b0;
    ex_halt  = 1'b0;
    ex_hi_we = 1'b0;
    ex_lo_we = 1'b0;
    ex_md    = 1'b0;
    ex_load  = 1'b0;
    ex_store = 1'b0;
    ex_mlast = 2'd3;
    unique case (op) inside
      OP_SPECIAL: begin
        ex_wr   = 1'b1;
        ex_widx = rd;
        unique case (fn) inside
          FN_SLL:  ex_wv = rf_b << sh;
          FN_SRL:  ex_wv = rf_b >> sh;
          FN_SRA:  ex_wv = 32'($signed(rf_b) >>> sh);
          FN_SLLV: ex_wv = rf_b << rf_a[4:0];
          FN_SRLV: ex_wv = rf_b >> rf_a[4:0];
          FN_SRAV: ex_wv = 32'($signed(rf_b) >>> rf_a[4:0]);
          FN_JR: begin
            ex_wr  = 1'b0;
            ex_npc = rf_a;
          end
          FN_JALR: begin
            ex_wv  = pc4;
            ex_npc = rf_a;
          end
          FN_SYSCALL: begin
            ex_wr   = 1'b0;
            ex_halt = 1'b1;
          end
          FN_MFHI: ex_wv = hi_q;
          FN_MFLO: ex_wv = lo_q;
          FN_MTHI: begin
            ex_wr    = 1'b0;
            ex_hi_we = 1'b1;
          end
          FN_MTLO: begin
            ex_wr    = 1'b0;
            ex_lo_we = 1'b1;
          end
          FN_MULT, FN_MULTU, FN_DIV, FN_DIVU: begin
            ex_wr = 1'b0;
            ex_md = 1'b1;
          end
          FN_ADD, FN_ADDU: ex_wv = rf_a + rf_b;
          FN_SUB, FN_SUBU: ex_wv = rf_a - rf_b;
          FN_AND:  ex_wv = rf_a & rf_b;
          FN_OR:   ex_wv = rf_a | rf_b;
          FN_XOR:  ex_wv = rf_a ^ rf_b;
          FN_NOR:  ex_wv = ~(rf_a | rf_b);
          FN_SLT:  ex_wv = {31'd0, $signed(rf_a) < $signed(rf_b)};
          FN_SLTU: ex_wv = {31'd0, rf_a < rf_b};
          default: begin
            ex_wr    = 1'b0;
            ex_undef = 1'b1;
          end
        endcase
      end
      OP_REGIMM: begin
        unique case (rt) inside
          RT_BLTZ, RT_BLTZAL: if (rf_a[31]) ex_npc = btarget;
          RT_BGEZ, RT_BGEZAL: if (!rf_a[31]) ex_npc = btarget;
          default: ex_undef = 1'b1;
        endcase
        // link regardless of the branch outcome
        if (rt == RT_BLTZAL || rt == RT_BGEZAL) begin
          ex_wr   = 1'b1;
          ex_widx = REG_LINK;
          ex_wv   = pc4;
        end
      end
      OP_J: ex_npc = {pc4[31:28], iw_q[25:0], 2'b00};
      OP_JAL: begin
        ex_npc  = {pc4[31:28], iw_q[25:0], 2'b00};
        ex_wr   = 1'b1;
        ex_widx = REG_LINK;
        ex_wv   = pc4;
      end
      OP_BEQ:  if (rf_a == rf_b) ex_npc = btarget;
      OP_BNE:  if (rf_a != rf_b) ex_npc = btarget;
      OP_BLEZ: if (rf_a == 32'd0 || rf_a[31]) ex_npc = btarget;
      OP_BGTZ: if (rf_a != 32'd0 && !rf_a[31]) ex_npc = btarget;
      OP_ADDI, OP_ADDIU: begin
        ex_wr = 1'b1; ex_widx = rt; ex_wv = rf_a + se;
      end
      OP_SLTI: begin
        ex_wr = 1'b1; ex_widx = rt; ex_wv = {31'd0, $signed(rf_a) < $signed(se)};
      end
      OP_SLTIU: begin
        ex_wr = 1'b1; ex_widx = rt; ex_wv = {31'd0, rf_a < se};
      end
      OP_ANDI: begin
        ex_wr = 1'b1; ex_widx = rt; ex_wv = rf_a & {16'd0, imm};
      end
      OP_ORI: begin
        ex_wr = 1'b1; ex_widx = rt; ex_wv = rf_a | {16'd0, imm};
      end
      OP_XORI: begin
        ex_wr = 1'b1; ex_widx = rt; ex_wv = rf_a ^ {16'd0, imm};
      end
      OP_LUI: begin
        ex_wr = 1'b1; ex_widx = rt; ex_wv = {imm, 16'd0};
      end
      OP_LB, OP_LBU: begin
        ex_load = 1'b1; ex_mlast = 2'd0;
      end
      OP_LH, OP_LHU: begin
        ex_load = 1'b1; ex_mlast = 2'd1;
      end
      OP_LW: ex_load = 1'b1;
      OP_SB: begin
        ex_store = 1'b1; ex_mlast = 2'd0;
      end
      OP_SH: begin
        ex_store = 1'b1; ex_mlast = 2'd1;
      end
      OP_SW: ex_store = 1'b1;
      default: ex_undef = 1'b1;
    endcase
  end

  // writes to register zero are dropped and reported as no write
  assign fin_wr = ex_wr && (ex_widx != REG_ZERO);

  // load formatting from the gathered bytes
  always_comb begin
    unique case (op) inside
      OP_LB:   ld_val = {{24{mword_q[7]}}, mword_q[7:0]};
      OP_LBU:  ld_val = {24'd0, mword_q[7:0]};
      OP_LH:   ld_val = {{16{mword_q[15]}}, mword_q[15:0]};
      OP_LHU:  ld_val = {16'd0, mword_q[15:0]};
      default: ld_val = mword_q;
    endcase
  end

  // store readback always covers the whole word
  assign rlast = mstore_q ? 2'd3 : mlast_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (operation_i == OPER_PRELOAD) begin
            state_d = S_MWR;
          end else if (halt_q) begin
            state_d = S_FIN;
          end else begin
            state_d = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        if (ex_md) begin
          state_d = S_MD;
        end else if (ex_store) begin
          state_d = S_MWR;
        end else if (ex_load) begin
          state_d = S_MRA;
        end else begin
          state_d = S_FIN;
        end
      end
      S_MD:   if (md_rsp.done) state_d = S_FIN;
      S_MWR:  if (mcnt_q == mlast_q) state_d = S_MRA;
      S_MRA:  state_d = S_MRB;
      S_MRB:  state_d = (mcnt_q == rlast) ? S_MEND : S_MRA;
      S_MEND: state_d = S_FIN;
      S_FIN:  if (fin_fire) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pc_q        <= START_PC_RESET;
      hi_q        <= '0;
      lo_q        <= '0;
      halt_q      <= 1'b0;
      start_pc_q  <= START_PC_RESET;
      out_valid_q <= 1'b0;
      mcnt_q      <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_wr) begin
        start_pc_q <= pwdata;
      end
      if (fin_fire) begin
        pc_q   <= res_q.next_pc;
        halt_q <= res_q.halted;
        if (rhi_we_q) hi_q <= rhi_q;
        if (rlo_we_q) lo_q <= rlo_q;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_MWR:   mcnt_q <= (mcnt_q == mlast_q) ? 2'd0 : mcnt_q + 2'd1;
        S_MRB:   mcnt_q <= mcnt_q + 2'd1;
        S_MRA:   mcnt_q <= mcnt_q;
        default: mcnt_q <= '0;
      endcase
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          iw_q              <= instruction_word_i;
          res_q             <= '0;
          res_q.executed_pc <= pc_q;
          res_q.next_pc     <= pc_q;
          res_q.halted      <= halt_q;
          rhi_we_q          <= 1'b0;
          rlo_we_q          <= 1'b0;
          mbase_q           <= DMEM_AW'(preload_address_i);
          mdata_q           <= preload_data_i;
          mlast_q           <= 2'd3;
          mstore_q          <= 1'b1;
          mword_q           <= '0;
        end
      end
      S_EXEC: begin
        res_q.next_pc         <= ex_npc;
        res_q.reg_written     <= fin_wr;
        res_q.reg_index       <= fin_wr ? ex_widx : REG_ZERO;
        res_q.reg_value       <= fin_wr ? ex_wv : '0;
        res_q.undefined_instr <= ex_undef;
        res_q.halted          <= ex_halt;
        rhi_we_q              <= ex_hi_we;
        rlo_we_q              <= ex_lo_we;
        rhi_q                 <= rf_a;
        rlo_q                 <= rf_a;
        mbase_q               <= ea[DMEM_AW-1:0];
        mdata_q               <= rf_b;
        mlast_q               <= ex_mlast;
        mstore_q              <= ex_store;
        mword_q               <= '0;
      end
      S_MD: begin
        if (md_rsp.done) begin
          rhi_q    <= md_rsp.hi;
          rlo_q    <= md_rsp.lo;
          rhi_we_q <= 1'b1;
          rlo_we_q <= 1'b1;
        end
      end
      S_MRB: mword_q[{mcnt_q, 3'b000} +: 8] <= dm_rdata;
      S_MEND: begin
        if (mstore_q) begin
          res_q.store_done    <= 1'b1;
          res_q.store_address <= 12'(mbase_q);
          res_q.store_value   <= mword_q;
        end else if (rt != REG_ZERO) begin
          res_q.reg_written <= 1'b1;
          res_q.reg_index   <= rt;
          res_q.reg_value   <= ld_val;
        end
      end
      S_FIN: if (fin_fire) out_q <= res_q;
      default: ;
    endcase
  end

  mips_regfile u_regfile (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ra_i      (instruction_word_i[25:21]),
    .rb_i      (instruction_word_i[20:16]),
    .rdata_a_o (rf_a),
    .rdata_b_o (rf_b),
    .we_i      (fin_fire && res_q.reg_written),
    .waddr_i   (res_q.reg_index),
    .wdata_i   (res_q.reg_value)
  );

  mips_dmem u_dmem (
    .clk_i   (clk_i),
    .we_i    (state_q == S_MWR),
    .addr_i  (mbase_q + DMEM_AW'(mcnt_q)),
    .wdata_i (mdata_q[{mcnt_q, 3'b000} +: 8]),
    .rdata_o (dm_rdata)
  );

  assign md_req.start     = (state_q == S_EXEC) && ex_md;
  assign md_req.is_div    = fn[1];
  assign md_req.is_signed = ~fn[0];

  mips_md u_md (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req),
    .a_i    (rf_a),
    .b_i    (rf_b),
    .rsp_o  (md_rsp)
  );

  assign out_valid_o       = out_valid_q;
  assign executed_pc_o     = out_q.executed_pc;
  assign next_pc_o         = out_q.next_pc;
  assign reg_written_o     = out_q.reg_written;
  assign reg_index_o       = out_q.reg_index;
  assign reg_value_o       = out_q.reg_value;
  assign store_done_o      = out_q.store_done;
  assign store_address_o   = out_q.store_address;
  assign store_value_o     = out_q.store_value;
  assign halted_o          = out_q.halted;
  assign undefined_instr_o = out_q.undefined_instr;

  a_no_zero_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin_fire && res_q.reg_written) |-> res_q.reg_index != REG_ZERO)
    else $error("write to register zero committed");

  a_halt_holds_pc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |=> $stable(pc_q))
    else $error("pc moved while halted");

  a_read_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MRB) |-> $past(state_q) == S_MRA)
    else $error("byte capture without issued read");

  a_store_or_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(store_done_o && reg_written_o))
    else $error("result reports both store and register write");

endmodule

>>> rtl/mips_regfile.sv
// general register file, two registered read ports, one write port
module mips_regfile import mips_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [4:0]  ra_i,
  input  logic [4:0]  rb_i,
  output logic [31:0] rdata_a_o,
  output logic [31:0] rdata_b_o,
  input  logic        we_i,
  input  logic [4:0]  waddr_i,
  input  logic [31:0] wdata_i
);

  logic [31:0] mem_q [32];
  logic [31:0] valid_q;
  logic [31:0] rdata_a_q;
  logic [31:0] rdata_b_q;

  // entries never written read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (we_i) begin
      valid_q[waddr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= valid_q[ra_i] ? mem_q[ra_i] : '0;
    rdata_b_q <= valid_q[rb_i] ? mem_q[rb_i] : '0;
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

>>> rtl/mips_dmem.sv
// byte-wide data memory, one port, registered read
module mips_dmem import mips_pkg::*; (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [DMEM_AW-1:0] addr_i,
  input  logic [7:0]         wdata_i,
  output logic [7:0]         rdata_o
);

  logic [7:0] mem_q [DMEM_BYTES];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/mips_md.sv
// iterative multiply and divide unit, one shared adder, one bit per cycle
module mips_md import mips_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  md_req_t     req_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output md_rsp_t     rsp_o
);

  localparam logic [1:0] MD_IDLE = 2'd0;
  localparam logic [1:0] MD_RUN  = 2'd1;
  localparam logic [1:0] MD_FIX  = 2'd2;
  localparam logic [1:0] MD_DONE = 2'd3;

  logic [1:0]  state_q, state_d;
  logic [4:0]  cnt_q;
  logic        div_q, zero_q, neg_q, nrem_q;
  logic [32:0] x_q;
  logic [31:0] y_q, m_q, a_q, hi_q, lo_q;
  logic [31:0] mag_a, mag_b;
  logic [32:0] add_x;
  logic [33:0] sum;
  logic [63:0] prod_neg;

  assign mag_a = (req_i.is_signed && a_i[31]) ? 32'd0 - a_i : a_i;
  assign mag_b = (req_i.is_signed && b_i[31]) ? 32'd0 - b_i : b_i;

  // shared adder: accumulate for multiply, trial subtract for divide
  assign add_x = div_q ? {x_q[31:0], y_q[31]} : x_q;
  assign sum   = div_q ? {1'b0, add_x} - {2'b00, m_q} : {1'b0, add_x} + {2'b00, m_q};
  assign prod_neg = 64'd0 - {x_q[31:0], y_q};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      MD_IDLE: if (req_i.start) state_d = MD_RUN;
      MD_RUN:  if (cnt_q == 5'd31) state_d = MD_FIX;
      MD_FIX:  state_d = MD_DONE;
      MD_DONE: state_d = MD_IDLE;
      default: state_d = MD_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MD_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == MD_RUN) begin
        cnt_q <= cnt_q + 5'd1;
      end else begin
        cnt_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      MD_IDLE: begin
        if (req_i.start) begin
          div_q  <= req_i.is_div;
          zero_q <= (b_i == 32'd0);
          neg_q  <= req_i.is_signed && (a_i[31] ^ b_i[31]);
          nrem_q <= req_i.is_signed && a_i[31];
          a_q    <= a_i;
          x_q    <= '0;
          y_q    <= mag_a;
          m_q    <= mag_b;
        end
      end
      MD_RUN: begin
        if (div_q) begin
          x_q <= sum[33] ? add_x : sum[32:0];
          y_q <= {y_q[30:0], ~sum[33]};
        end else if (y_q[0]) begin
          x_q <= {1'b0, sum[32:1]};
          y_q <= {sum[0], y_q[31:1]};
        end else begin
          x_q <= {1'b0, x_q[32:1]};
          y_q <= {x_q[0], y_q[31:1]};
        end
      end
      MD_FIX: begin
        if (!div_q) begin
          {hi_q, lo_q} <= neg_q ? prod_neg : {x_q[31:0], y_q};
        end else if (zero_q) begin
          hi_q <= a_q;
          lo_q <= '1;
        end else begin
          hi_q <= nrem_q ? 32'd0 - x_q[31:0] : x_q[31:0];
          lo_q <= neg_q ? 32'd0 - y_q : y_q;
        end
      end
      default: ;
    endcase
  end

  assign rsp_o.done = (state_q == MD_DONE);
  assign rsp_o.hi   = hi_q;
  assign rsp_o.lo   = lo_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> state_q == MD_IDLE)
    else $error("md start while busy");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.done |=> !rsp_o.done)
    else $error("md done longer than one cycle");

  a_run_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == MD_FIX) |-> $past(cnt_q) == 5'd31)
    else $error("md fixup before all steps");

endmodule

>>> verif/mips32_instruction_execute_checker.sv
// checker for the mips32 instruction execute block: predicts each result and compares it
module mips32_instruction_execute_checker import mips_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        operation_i,
  input  logic [31:0] instruction_word_i,
  input  logic [11:0] preload_address_i,
  input  logic [31:0] preload_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [31:0] executed_pc_i,
  input  logic [31:0] next_pc_i,
  input  logic        reg_written_i,
  input  logic [4:0]  reg_index_i,
  input  logic [31:0] reg_value_i,
  input  logic        store_done_i,
  input  logic [11:0] store_address_i,
  input  logic [31:0] store_value_i,
  input  logic        halted_i,
  input  logic        undefined_instr_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [31:0] gpr [32];
  logic [31:0] pc_q = START_PC_RESET;
  logic [31:0] hi_q = '0;
  logic [31:0] lo_q = '0;
  logic        halt_q = 1'b0;
  logic [7:0]  dmem [DMEM_BYTES];
  out_t        expected_results [$];
  int          errors = 0;

  initial begin
    foreach (gpr[i]) gpr[i] = '0;
    foreach (dmem[i]) dmem[i] = '0;
  end

  assign fail_count_o = errors;
  assign pending_o    = expected_results.size();

  function automatic logic [31:0] mem_read(logic [31:0] addr, int n);
    logic [31:0] v;
    v = '0;
    for (int i = 0; i < n; i++) v[8*i +: 8] = dmem[(addr + i) % DMEM_BYTES];
    return v;
  endfunction

  function automatic void mem_write(logic [31:0] addr, logic [31:0] v, int n);
    for (int i = 0; i < n; i++) dmem[(addr + i) % DMEM_BYTES] = v[8*i +: 8];
  endfunction

  // one instruction or preload against the shadow architectural state
  function automatic out_t execute_step(logic oper, logic [31:0] w, logic [11:0] pa,
                                        logic [31:0] pd);
    out_t        r;
    logic [31:0] pc, npc, a, b, se, bt, ea, wv, ma, mb, q, rm;
    logic [5:0]  opc, fn;
    logic [4:0]  rs, rt, rd, sh, widx;
    logic        wr, st, und, neg;
    logic [63:0] p;
    int          n;
    pc = pc_q; npc = pc + 4;
    wr = 0; st = 0; und = 0; widx = '0; wv = '0;
    r = '0;
    if (oper == OPER_PRELOAD) begin
      mem_write({20'd0, pa}, pd, 4);
      st = 1; r.store_address = pa; r.store_value = mem_read({20'd0, pa}, 4);
      npc = pc;
    end else if (halt_q) begin
      npc = pc;
    end else begin
      opc = w[31:26]; fn = w[5:0];
      rs = w[25:21]; rt = w[20:16]; rd = w[15:11]; sh = w[10:6];
      a = gpr[rs]; b = gpr[rt];
      se = {{16{w[15]}}, w[15:0]};
      bt = pc + 4 + (se << 2);
      ea = a + se;
      if (opc == OP_SPECIAL) begin
        wr = 1; widx = rd;
        case (fn)
          FN_SLL:     wv = b << sh;
          FN_SRL:     wv = b >> sh;
          FN_SRA:     wv = $signed(b) >>> sh;
          FN_SLLV:    wv = b << a[4:0];
          FN_SRLV:    wv = b >> a[4:0];
          FN_SRAV:    wv = $signed(b) >>> a[4:0];
          FN_JR:      begin wr = 0; npc = a; end
          FN_JALR:    begin wv = pc + 4; npc = a; end
          FN_SYSCALL: begin wr = 0; halt_q = 1; end
          FN_MFHI:    wv = hi_q;
          FN_MTHI:    begin wr = 0; hi_q = a; end
          FN_MFLO:    wv = lo_q;
          FN_MTLO:    begin wr = 0; lo_q = a; end
          FN_MULT, FN_MULTU: begin
            wr = 0;
            if (fn == FN_MULT) p = {{32{a[31]}}, a} * {{32{b[31]}}, b};
            else p = {32'd0, a} * {32'd0, b};
            lo_q = p[31:0]; hi_q = p[63:32];
          end
          FN_DIV, FN_DIVU: begin
            wr = 0;
            if (b == 0) begin
              lo_q = '1; hi_q = a;
            end else if (fn == FN_DIVU) begin
              lo_q = a / b; hi_q = a % b;
            end else begin
              ma = a[31] ? -a : a; mb = b[31] ? -b : b;
              q = ma / mb; rm = ma % mb;
              lo_q = (a[31] != b[31]) ? -q : q;
              hi_q = a[31] ? -rm : rm;
            end
          end
          FN_ADD, FN_ADDU: wv = a + b;
          FN_SUB, FN_SUBU: wv = a - b;
          FN_AND:  wv = a & b;
          FN_OR:   wv = a | b;
          FN_XOR:  wv = a ^ b;
          FN_NOR:  wv = ~(a | b);
          FN_SLT:  wv = {31'd0, $signed(a) < $signed(b)};
          FN_SLTU: wv = {31'd0, a < b};
          default: begin wr = 0; und = 1; end
        endcase
      end else if (opc == OP_REGIMM) begin
        neg = a[31];
        if (rt == RT_BLTZ || rt == RT_BLTZAL) begin
          if (neg) npc = bt;
        end else if (rt == RT_BGEZ || rt == RT_BGEZAL) begin
          if (!neg) npc = bt;
        end else begin
          und = 1;
        end
        if (rt == RT_BLTZAL || rt == RT_BGEZAL) begin
          wr = 1; widx = REG_LINK; wv = pc + 4;
        end
      end else begin
        case (opc)
          OP_J:    npc = {npc[31:28], w[25:0], 2'b00};
          OP_JAL:  begin
            wr = 1; widx = REG_LINK; wv = pc + 4;
            npc = {npc[31:28], w[25:0], 2'b00};
          end
          OP_BEQ:  if (a == b) npc = bt;
          OP_BNE:  if (a != b) npc = bt;
          OP_BLEZ: if (a == 0 || a[31]) npc = bt;
          OP_BGTZ: if (a != 0 && !a[31]) npc = bt;
          OP_ADDI, OP_ADDIU: begin wr = 1; widx = rt; wv = a + se; end
          OP_SLTI:  begin wr = 1; widx = rt; wv = {31'd0, $signed(a) < $signed(se)}; end
          OP_SLTIU: begin wr = 1; widx = rt; wv = {31'd0, a < se}; end
          OP_ANDI:  begin wr = 1; widx = rt; wv = a & {16'd0, w[15:0]}; end
          OP_ORI:   begin wr = 1; widx = rt; wv = a | {16'd0, w[15:0]}; end
          OP_XORI:  begin wr = 1; widx = rt; wv = a ^ {16'd0, w[15:0]}; end
          OP_LUI:   begin wr = 1; widx = rt; wv = {w[15:0], 16'd0}; end
          OP_LB:  begin
            wr = 1; widx = rt; q = mem_read(ea, 1); wv = {{24{q[7]}}, q[7:0]};
          end
          OP_LH:  begin
            wr = 1; widx = rt; q = mem_read(ea, 2); wv = {{16{q[15]}}, q[15:0]};
          end
          OP_LW:  begin wr = 1; widx = rt; wv = mem_read(ea, 4); end
          OP_LBU: begin wr = 1; widx = rt; wv = mem_read(ea, 1); end
          OP_LHU: begin wr = 1; widx = rt; wv = mem_read(ea, 2); end
          OP_SB, OP_SH, OP_SW: begin
            n = (opc == OP_SB) ? 1 : (opc == OP_SH) ? 2 : 4;
            mem_write(ea, b, n);
            st = 1; r.store_address = ea[11:0]; r.store_value = mem_read(ea, 4);
          end
          default: und = 1;
        endcase
      end
    end
    if (wr && widx != REG_ZERO) gpr[widx] = wv;
    else begin wr = 0; widx = '0; wv = '0; end
    gpr[0] = '0;
    pc_q = npc;
    r.executed_pc = pc; r.next_pc = npc;
    r.reg_written = wr; r.reg_index = widx; r.reg_value = wv;
    r.store_done = st; r.halted = halt_q; r.undefined_instr = und;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, exp_v, act_v);
    end
  endfunction

  always @(posedge clk_i) begin
    out_t e;
    if (rst_ni && in_valid_i && in_ready_i)
      expected_results.push_back(execute_step(operation_i, instruction_word_i,
                                              preload_address_i, preload_data_i));
    if (rst_ni && out_valid_i && out_ready_i) begin
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: result with no request waiting, pc %h", $realtime, executed_pc_i);
      end else begin
        e = expected_results.pop_front();
        check_field("executed_pc", e.executed_pc, executed_pc_i);
        check_field("next_pc", e.next_pc, next_pc_i);
        check_field("reg_written", 32'(e.reg_written), 32'(reg_written_i));
        check_field("reg_index", 32'(e.reg_index), 32'(reg_index_i));
        check_field("reg_value", e.reg_value, reg_value_i);
        check_field("store_done", 32'(e.store_done), 32'(store_done_i));
        check_field("store_address", 32'(e.store_address), 32'(store_address_i));
        check_field("store_value", e.store_value, store_value_i);
        check_field("halted", 32'(e.halted), 32'(halted_i));
        check_field("undefined_instr", 32'(e.undefined_instr), 32'(undefined_instr_i));
      end
    end
  end

endmodule

>>> verif/tb_mips32_instruction_execute.sv
// testbench top for the mips32 instruction execute block: stimulus and verdict
module tb_mips32_instruction_execute;
  import mips_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_REQUESTS = 1200;
  localparam int STALL_LIMIT     = 20000;  // cycles with no handshake at all
  localparam int HOLD_CYCLES     = 300;    // long receiver hold-off

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        operation_i;
  logic [31:0] instruction_word_i;
  logic [11:0] preload_address_i;
  logic [31:0] preload_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [31:0] executed_pc_o;
  logic [31:0] next_pc_o;
  logic        reg_written_o;
  logic [4:0]  reg_index_o;
  logic [31:0] reg_value_o;
  logic        store_done_o;
  logic [11:0] store_address_o;
  logic [31:0] store_value_o;
  logic        halted_o;
  logic        undefined_instr_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int fail_count;
  int pending;

  // run-time knobs; no_idle is shared by both sides of the block
  logic no_idle   = 1'b0;  // stretch where neither side idles
  logic hold_go   = 1'b0;  // asks the receiver for its long hold-off
  int   stall_cnt = 0;

  // bytes of data memory known to hold a written value; loads and partial
  // stores are only aimed at these so no unwritten byte is ever read
  logic byte_written [DMEM_BYTES];

  mips32_instruction_execute DUT (.*);

  mips32_instruction_execute_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i(in_ready_o),
    .operation_i, .instruction_word_i, .preload_address_i, .preload_data_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .executed_pc_i(executed_pc_o), .next_pc_i(next_pc_o),
    .reg_written_i(reg_written_o), .reg_index_i(reg_index_o), .reg_value_i(reg_value_o),
    .store_done_i(store_done_o), .store_address_i(store_address_o),
    .store_value_i(store_value_o), .halted_i(halted_o),
    .undefined_instr_i(undefined_instr_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog: ends the run when no request or result moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stall_cnt <= 0;
    else if (stall_cnt >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else stall_cnt <= stall_cnt + 1;
  end

  // result side: random back-pressure, one long hold-off counted here
  initial begin
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_go && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1;
      end
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else if (no_idle) out_ready_i <= 1'b1;
      else out_ready_i <= ($urandom_range(0, 99) >= 36);
    end
  end

  // instruction encoders
  function automatic logic [31:0] enc_r(logic [5:0] fn, logic [4:0] rs, logic [4:0] rt,
                                        logic [4:0] rd, logic [4:0] sh);
    return {OP_SPECIAL, rs, rt, rd, sh, fn};
  endfunction

  function automatic logic [31:0] enc_i(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                        logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  function automatic bit bytes_ready(logic [11:0] addr, int n);
    for (int i = 0; i < n; i++)
      if (!byte_written[(addr + i) % DMEM_BYTES]) return 0;
    return 1;
  endfunction

  function automatic void mark_bytes(logic [11:0] addr, int n);
    for (int i = 0; i < n; i++) byte_written[(addr + i) % DMEM_BYTES] = 1'b1;
  endfunction

  // mostly a small hot window so loads find written bytes, sometimes anywhere
  function automatic logic [11:0] pick_addr();
    if ($urandom_range(0, 99) < 80) return 12'($urandom_range(0, 63));
    return 12'($urandom_range(0, DMEM_BYTES - 1));
  endfunction

  // one request; valid stays high until the block takes it
  task automatic send(logic oper, logic [31:0] w, logic [11:0] pa, logic [31:0] pd);
    @(negedge clk_i);
    while (!no_idle && $urandom_range(0, 99) < 36) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i         <= 1'b1;
    operation_i        <= oper;
    instruction_word_i <= w;
    preload_address_i  <= pa;
    preload_data_i     <= pd;
    // ready only moves at the rising edge, so it is looked at on the falling edge before it
    while (!in_ready_o) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // execute request; the unused preload fields carry random bits
  task automatic exec(logic [31:0] w);
    if (w[25:21] == REG_ZERO) begin
      // base register zero: the store address is known here
      if (w[31:26] == OP_SB) mark_bytes(w[11:0], 1);
      if (w[31:26] == OP_SH) mark_bytes(w[11:0], 2);
      if (w[31:26] == OP_SW) mark_bytes(w[11:0], 4);
    end
    send(1'b0, w, 12'($urandom), $urandom);
  endtask

  task automatic preload(logic [11:0] addr, logic [31:0] data);
    mark_bytes(addr, 4);
    send(OPER_PRELOAD, $urandom, addr, data);
  endtask

  task automatic drop_valid();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic apb_write(logic [31:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_START_PC, 2'b00};
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // block idle: no request offered and every result back
  task automatic wait_drained();
    drop_valid();
    wait (pending == 0);
    repeat (10) @(posedge clk_i);
  endtask

  // load or store off register zero, else a preload to make room
  task automatic mem_access();
    logic [11:0] a;
    logic [5:0]  op;
    int          k, need;
    a = pick_addr();
    k = $urandom_range(0, 7);
    case (k)
      0: begin op = OP_LB;  need = 1; end
      1: begin op = OP_LH;  need = 2; end
      2: begin op = OP_LW;  need = 4; end
      3: begin op = OP_LBU; need = 1; end
      4: begin op = OP_LHU; need = 2; end
      5: begin op = OP_SB;  need = 4; end
      6: begin op = OP_SH;  need = 4; end
      default: begin op = OP_SW; need = 0; end
    endcase
    // the offset's upper nibble does not change the wrapped address
    if (bytes_ready(a, need))
      exec(enc_i(op, REG_ZERO, 5'($urandom), {4'($urandom), a}));
    else preload(a, $urandom);
  endtask

  // random instruction mix, never a syscall and never a read of unknown memory
  task automatic random_request();
    logic [31:0] w;
    int          r;
    logic [5:0]  fn;
    r = $urandom_range(0, 99);
    if (r < 8) preload(pick_addr(), $urandom);
    else if (r < 28) mem_access();
    else if (r < 32) begin
      // word store off any base: writes every byte it reads back
      w = $urandom;
      exec({OP_SW, w[25:0]});
    end else if (r < 42) begin
      w = $urandom;
      case ($urandom_range(0, 6))
        0: exec({OP_REGIMM, w[25:0]});
        1: exec({OP_J, w[25:0]});
        2: exec({OP_JAL, w[25:0]});
        3: exec({OP_BEQ, w[25:0]});
        4: exec({OP_BNE, w[25:0]});
        5: exec({OP_BLEZ, w[25:0]});
        default: exec({OP_BGTZ, w[25:0]});
      endcase
    end else if (r < 55) begin
      case ($urandom_range(0, 9))
        0: fn = FN_JR;   1: fn = FN_JALR;  2: fn = FN_MFHI;  3: fn = FN_MTHI;
        4: fn = FN_MFLO; 5: fn = FN_MTLO;  6: fn = FN_MULT;  7: fn = FN_MULTU;
        8: fn = FN_DIV;  default: fn = FN_DIVU;
      endcase
      w = $urandom;
      // keep divisors often zero to hit the zero-divide case
      if ((fn == FN_DIV || fn == FN_DIVU) && $urandom_range(0, 3) == 0) w[20:16] = REG_ZERO;
      exec(enc_r(fn, w[25:21], w[20:16], w[15:11], w[10:6]));
    end else if (r < 72) begin
      case ($urandom_range(0, 17))
        0: fn = FN_SLL;  1: fn = FN_SRL;  2: fn = FN_SRA;  3: fn = FN_SLLV;
        4: fn = FN_SRLV; 5: fn = FN_SRAV; 6: fn = FN_ADD;  7: fn = FN_ADDU;
        8: fn = FN_SUB;  9: fn = FN_SUBU; 10: fn = FN_AND; 11: fn = FN_OR;
        12: fn = FN_XOR; 13: fn = FN_NOR; 14: fn = FN_SLT; default: fn = FN_SLTU;
      endcase
      w = $urandom;
      exec(enc_r(fn, w[25:21], w[20:16], w[15:11], w[10:6]));
    end else if (r < 90) begin
      w = $urandom;
      case ($urandom_range(0, 7))
        0: exec({OP_ADDI, w[25:0]});  1: exec({OP_ADDIU, w[25:0]});
        2: exec({OP_SLTI, w[25:0]});  3: exec({OP_SLTIU, w[25:0]});
        4: exec({OP_ANDI, w[25:0]});  5: exec({OP_ORI, w[25:0]});
        6: exec({OP_XORI, w[25:0]});  default: exec({OP_LUI, w[25:0]});
      endcase
    end else begin
      // raw word, undefined codes included
      do begin
        w = $urandom;
      end while (w[31:26] inside {OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU, OP_SB, OP_SH} ||
                 (w[31:26] == OP_SPECIAL && w[5:0] == FN_SYSCALL));
      exec(w);
    end
  endtask

  initial begin
    foreach (byte_written[i]) byte_written[i] = 1'b0;
    rst_ni             = 1'b0;
    in_valid_i         = 1'b0;
    operation_i        = 1'b0;
    instruction_word_i = '0;
    preload_address_i  = '0;
    preload_data_i     = '0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // start_pc is only a readable copy, so writes must not move the pc
    apb_write('1);

    // directed: memory seeded at both ends, including a word across the wrap
    preload(12'h000, 32'h8000_00ff);
    preload(12'hffc, 32'h7fff_8001);
    preload(12'hffe, 32'h1234_80ff);
    exec(enc_i(OP_LUI, REG_ZERO, 5'd1, 16'h8000));       // most negative
    exec(enc_i(OP_ADDIU, REG_ZERO, 5'd2, 16'hffff));     // minus one
    exec(enc_i(OP_ADDI, 5'd1, 5'd3, 16'hffff));          // wraps, no trap
    exec(enc_r(FN_SUB, REG_ZERO, 5'd1, 5'd4, 5'd0));     // wraps, no trap
    exec(enc_r(FN_SRA, REG_ZERO, 5'd1, 5'd5, 5'd31));
    exec(enc_r(FN_SLT, 5'd1, 5'd2, 5'd6, 5'd0));
    exec(enc_r(FN_SLTU, 5'd1, 5'd2, 5'd7, 5'd0));
    exec(enc_r(FN_MULT, 5'd1, 5'd1, REG_ZERO, 5'd0));    // full 64-bit product
    exec(enc_r(FN_MFHI, REG_ZERO, REG_ZERO, 5'd8, 5'd0));
    exec(enc_r(FN_MULTU, 5'd2, 5'd2, REG_ZERO, 5'd0));
    exec(enc_r(FN_DIV, 5'd1, 5'd2, REG_ZERO, 5'd0));     // most negative by minus one
    exec(enc_r(FN_MFLO, REG_ZERO, REG_ZERO, 5'd9, 5'd0));
    exec(enc_r(FN_DIVU, 5'd2, REG_ZERO, REG_ZERO, 5'd0)); // divide by zero
    exec(enc_r(FN_MFHI, REG_ZERO, REG_ZERO, 5'd10, 5'd0));
    exec(enc_i(OP_LH, REG_ZERO, 5'd11, 16'hffff));       // halfword across the wrap
    exec(enc_i(OP_LW, REG_ZERO, 5'd12, 16'h0ffe));
    exec(enc_i(OP_SB, REG_ZERO, 5'd2, 16'h0000));        // only one byte changes
    exec(enc_i(OP_SH, REG_ZERO, 5'd1, 16'h0ffe));
    exec(enc_r(FN_JALR, 5'd1, REG_ZERO, 5'd1, 5'd0));    // link into its own base
    exec(enc_i(OP_ADDIU, REG_ZERO, REG_ZERO, 16'h7fff)); // discarded write to zero
    exec(enc_i(OP_BEQ, REG_ZERO, REG_ZERO, 16'h8000));   // most negative offset
    exec({OP_REGIMM, 5'd2, RT_BGEZAL, 16'h7fff});
    exec({OP_JAL, 26'h3ff_ffff});
    exec(32'hfc00_0000);                                 // undefined primary code
    wait_drained();
    apb_write('0);

    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i == 300) hold_go = 1'b1;
      if (i == 500) wait_drained();                     // sender pause until drained
      if (i == 600) begin
        wait_drained();
        apb_write($urandom);
      end
      if (i == 700) no_idle = 1'b1;
      if (i == 900) no_idle = 1'b0;
      random_request();
    end

    // halt, then requests while halted: execute does nothing, preload still works
    exec(enc_r(FN_SYSCALL, 5'($urandom), 5'($urandom), 5'($urandom), 5'($urandom)));
    repeat (4) exec($urandom);
    preload(12'($urandom), $urandom);
    exec(enc_i(OP_LW, 5'($urandom), 5'($urandom), 16'($urandom)));
    wait_drained();
    apb_write(START_PC_RESET);
    repeat (50) @(posedge clk_i);

    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

>>> filelist.f
rtl/mips_pkg.sv
rtl/mips_regfile.sv
rtl/mips_dmem.sv
rtl/mips_md.sv
rtl/mips32_instruction_execute.sv
verif/mips32_instruction_execute_checker.sv
verif/tb_mips32_instruction_execute.sv
